// ===== rtl/sau_pkg.sv =====
`default_nettype none
package sau_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_GAMMA
  } sau_state_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_MUL,
    G_CMP,
    G_DONE
  } sau_gstate_t;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SCALE  = 2'd2;

  localparam logic [7:0]  WIDTH_RESET  = 8'd128;
  localparam logic [7:0]  HEIGHT_RESET = 8'd128;
  localparam logic [31:0] SCALE_RESET  = 32'd65536;

  // 255.99^2 scaled by 10000
  localparam logic [29:0] GAIN_SQ_NUM = 30'd655308801;
  localparam logic [13:0] GAIN_SQ_DEN = 14'd10000;

endpackage
`default_nettype wire

// ===== rtl/sau_if.sv =====
`default_nettype none
interface sau_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [6:0]  pos_x;
  logic [6:0]  pos_y;
  logic [23:0] add_red;
  logic [23:0] add_green;
  logic [23:0] add_blue;
  modport source (output valid, operation, pos_x, pos_y, add_red, add_green, add_blue,
                  input ready);
  modport sink (input valid, operation, pos_x, pos_y, add_red, add_green, add_blue,
                output ready);
endinterface

interface sau_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [6:0] out_col;
  logic [6:0] out_row;
  logic       out_of_range;
  modport source (output valid, out_red, out_green, out_blue, out_col, out_row,
                  out_of_range, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_col, out_row,
                out_of_range, output ready);
endinterface
`default_nettype wire

// ===== rtl/sau_gamma.sv =====
`default_nettype none
module sau_gamma (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] sum,
  input  wire logic [31:0] scale,
  output logic             done,
  output logic [7:0]       gbyte
);

  sau_pkg::sau_gstate_t gst_r, gst_nxt;
  logic [7:0]  b_r;
  logic [15:0] bsq_r;
  logic [15:0] csq_r;
  logic [2:0]  bit_r;
  logic [45:0] lim_r;
  logic [61:0] rhs_r;
  logic [38:0] plo_r;
  logic [38:0] phi_r;
  logic [15:0] csq;
  logic [61:0] tot;
  logic        special;

  assign special = (scale == 32'd0) || (sum >= scale);
  // c^2 = b^2 + 2*b*2^k + 2^(2k), with b holding only bits above k
  assign csq = bsq_r + ({8'd0, b_r} << ({1'b0, bit_r} + 4'd1))
             + (16'd1 << ({1'b0, bit_r} << 1));
  assign tot = {phi_r[38:0], 23'd0} + {23'd0, plo_r};

  always_comb begin
    gst_nxt = gst_r;
    unique case (gst_r)
      sau_pkg::G_IDLE, sau_pkg::G_DONE: begin
        if (start) gst_nxt = special ? sau_pkg::G_DONE : sau_pkg::G_MUL;
      end
      sau_pkg::G_MUL: gst_nxt = sau_pkg::G_CMP;
      sau_pkg::G_CMP: gst_nxt = (bit_r == 3'd0) ? sau_pkg::G_DONE : sau_pkg::G_MUL;
      default: gst_nxt = sau_pkg::G_IDLE;
    endcase
  end

  always_comb begin
    done  = (gst_r == sau_pkg::G_DONE);
    gbyte = b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) gst_r <= sau_pkg::G_IDLE;
    else gst_r <= gst_nxt;
  end

  always_ff @(posedge clk) begin
    if (start && (gst_r == sau_pkg::G_IDLE || gst_r == sau_pkg::G_DONE)) begin
      if (scale == 32'd0) b_r <= (sum != 32'd0) ? 8'd255 : 8'd0;
      else if (sum >= scale) b_r <= 8'd255;
      else b_r <= 8'd0;
      bsq_r <= 16'd0;
      bit_r <= 3'd7;
      lim_r <= 46'(scale * sau_pkg::GAIN_SQ_DEN);
      rhs_r <= 62'(sum * sau_pkg::GAIN_SQ_NUM);
    end else if (gst_r == sau_pkg::G_MUL) begin
      csq_r <= csq;
      plo_r <= 39'(csq * lim_r[22:0]);
      phi_r <= 39'(csq * lim_r[45:23]);
    end else if (gst_r == sau_pkg::G_CMP) begin
      // keep the trial bit when its square still fits
      if (tot <= rhs_r) begin
        b_r   <= b_r | (8'd1 << bit_r);
        bsq_r <= csq_r;
      end
      bit_r <= bit_r - 3'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/splat_accumulate_gamma_readout.sv =====
`default_nettype none
// channel | dir | payload
// in_ch   | in  | operation, pos_x, pos_y, add_red, add_green, add_blue
// out_ch  | out | out_red, out_green, out_blue, out_col, out_row, out_of_range
// cfg_*   | in  | cfg_we, cfg_index, cfg_wdata (write only)
// Add: accept with memory read, then saturating write-back.
// Read: outside the image the result is loaded straight from the fetch; inside,
// the bit-serial gamma root (8 trial bits, multiply then compare) runs first,
// and it is cut short when every colour takes the clamped or zero-scale shortcut.
// After reset a clearing pass writes one pixel a cycle, all MAX_WIDTH*MAX_HEIGHT
// pixels, before the first request is taken. A stalled result holds the block
// only when a further read finishes.
module splat_accumulate_gamma_readout #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sau_in_if.sink           in_ch,
  sau_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sau_pkg::sau_state_t state_r, state_nxt;

  logic [7:0]  width_r;
  logic [7:0]  height_r;
  logic [31:0] scale_r;

  logic [95:0] mem [DEPTH];
  logic [95:0] rd_data_r;
  logic [95:0] wr_data;
  logic [AW-1:0] wr_addr;
  logic          mem_we;
  logic [AW-1:0] clr_cnt_r;

  logic          op_r;
  logic          inside_r;
  logic [6:0]    x_r;
  logic [6:0]    row_r;
  logic [AW-1:0] addr_r;
  logic [23:0]   add_r_r, add_g_r, add_b_r;

  logic [12:0] ew, eh;
  logic        in_image;
  logic [31:0] addr_full;
  logic [AW-1:0] addr;
  logic [12:0]   row_full;

  logic out_free, out_load, g_start, in_accept;
  logic g_done_r, g_done_g, g_done_b, g_done;
  logic [7:0] g_r, g_g, g_b;

  logic       out_valid_r;
  logic [7:0] o_red_r, o_green_r, o_blue_r;
  logic [6:0] o_col_r, o_row_r;
  logic       o_oor_r;

  function automatic logic [31:0] sat_add(input logic [31:0] s, input logic [23:0] a);
    logic [32:0] t;
    t = {1'b0, s} + {9'd0, a};
    return t[32] ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  assign ew = (13'(width_r) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_r);
  assign eh = (13'(height_r) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(height_r);
  assign in_image  = (13'(in_ch.pos_x) < ew) && (13'(in_ch.pos_y) < eh);
  assign addr_full = 32'(in_ch.pos_y) * 32'(MAX_WIDTH) + 32'(in_ch.pos_x);
  assign addr      = addr_full[AW-1:0];
  assign row_full  = eh - 13'd1 - 13'(in_ch.pos_y);
  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  // colours may take the shortcut independently, so wait for all three
  assign g_done    = g_done_r && g_done_g && g_done_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sau_pkg::ST_CLEAR: if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = sau_pkg::ST_IDLE;
      sau_pkg::ST_IDLE:  if (in_ch.valid) state_nxt = sau_pkg::ST_FETCH;
      sau_pkg::ST_FETCH: begin
        if (op_r == sau_pkg::OP_ADD) state_nxt = sau_pkg::ST_IDLE;
        else if (inside_r) state_nxt = sau_pkg::ST_GAMMA;
        else if (out_free) state_nxt = sau_pkg::ST_IDLE;
      end
      sau_pkg::ST_GAMMA: if (g_done && out_free) state_nxt = sau_pkg::ST_IDLE;
      default: state_nxt = sau_pkg::ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    wr_addr     = addr_r;
    wr_data     = {sat_add(rd_data_r[95:64], add_r_r), sat_add(rd_data_r[63:32], add_g_r),
                   sat_add(rd_data_r[31:0], add_b_r)};
    g_start     = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      sau_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
      end
      sau_pkg::ST_IDLE: in_ch.ready = 1'b1;
      sau_pkg::ST_FETCH: begin
        mem_we   = (op_r == sau_pkg::OP_ADD) && inside_r;
        g_start  = (op_r == sau_pkg::OP_READ) && inside_r;
        out_load = (op_r == sau_pkg::OP_READ) && !inside_r && out_free;
      end
      sau_pkg::ST_GAMMA: out_load = g_done && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sau_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
      width_r   <= sau_pkg::WIDTH_RESET;
      height_r  <= sau_pkg::HEIGHT_RESET;
      scale_r   <= sau_pkg::SCALE_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == sau_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cfg_we) begin
        unique case (cfg_index)
          sau_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[7:0];
          sau_pkg::CFG_HEIGHT: height_r <= cfg_wdata[7:0];
          sau_pkg::CFG_SCALE:  scale_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // pixel memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (in_accept) rd_data_r <= mem[addr];
  end

  // hold the request
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r     <= in_ch.operation;
      inside_r <= in_image;
      x_r      <= in_ch.pos_x;
      row_r    <= row_full[6:0];
      addr_r   <= addr;
      add_r_r  <= in_ch.add_red;
      add_g_r  <= in_ch.add_green;
      add_b_r  <= in_ch.add_blue;
    end
  end

  sau_gamma u_gamma_r (.clk, .rst_n, .start(g_start), .sum(rd_data_r[95:64]),
                       .scale(scale_r), .done(g_done_r), .gbyte(g_r));
  sau_gamma u_gamma_g (.clk, .rst_n, .start(g_start), .sum(rd_data_r[63:32]),
                       .scale(scale_r), .done(g_done_g), .gbyte(g_g));
  sau_gamma u_gamma_b (.clk, .rst_n, .start(g_start), .sum(rd_data_r[31:0]),
                       .scale(scale_r), .done(g_done_b), .gbyte(g_b));

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_red_r   <= inside_r ? g_r : 8'd0;
      o_green_r <= inside_r ? g_g : 8'd0;
      o_blue_r  <= inside_r ? g_b : 8'd0;
      o_col_r   <= inside_r ? x_r : 7'd0;
      o_row_r   <= inside_r ? row_r : 7'd0;
      o_oor_r   <= !inside_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_red      = o_red_r;
  assign out_ch.out_green    = o_green_r;
  assign out_ch.out_blue     = o_blue_r;
  assign out_ch.out_col      = o_col_r;
  assign out_ch.out_row      = o_row_r;
  assign out_ch.out_of_range = o_oor_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over a waiting one");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == sau_pkg::ST_CLEAR) || (state_r == sau_pkg::ST_FETCH))
    else $error("memory written outside clear or write-back");

  a_no_take_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sau_pkg::ST_CLEAR) |-> !in_ch.ready && !out_valid_r)
    else $error("traffic during clearing pass");

  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sau_pkg::ST_FETCH
                        || $past(state_r) == sau_pkg::ST_GAMMA)
    else $error("result without a read");

endmodule
`default_nettype wire
